// ===== design/ietf_pkg.sv =====
`default_nettype none

package ietf_pkg;

  localparam int MAX_PIECES = 32;
  localparam int PIECE_W    = 5;
  // piece counter saturates at MAX_PIECES, one bit above the index width
  localparam int PIDX_W     = PIECE_W + 1;
  localparam int CFG_W      = 64;

  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_COMMA   = 8'h2c;
  localparam logic [7:0] CHAR_DASH    = 8'h2d;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  typedef enum logic [1:0] {
    VK_INCLUDE     = 2'd0,
    VK_EXCLUDE     = 2'd1,
    VK_NO_INCLUDES = 2'd2,
    VK_NO_MATCH    = 2'd3
  } ietf_verdict_e;

  typedef enum logic {
    PS_IDLE,
    PS_SWEEP
  } ietf_pstate_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       byte_present;
    logic       last_byte;
  } ietf_text_t;

  typedef struct packed {
    logic               passes;
    logic [1:0]         verdict_kind;
    logic [PIECE_W-1:0] deciding_piece;
  } ietf_verdict_t;

  // attribute write from the parser into the cell row
  typedef struct packed {
    logic               start;
    logic               cont;
    logic [PIECE_W-1:0] end_idx;
  } ietf_cell_wr_t;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
      r = c - CASE_OFFSET;
    end
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c inside {CHAR_SPACE, CHAR_TAB};
  endfunction

endpackage

`default_nettype wire

// ===== design/ietf_stream_if.sv =====
`default_nettype none

interface ietf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== design/ietf_cell.sv =====
`default_nettype none

module ietf_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [7:0]                   filt_byte_i,
  input  logic [7:0]                   char_i,
  input  logic                         step_i,
  input  logic                         prev_i,
  input  logic                         sweep_sel_i,
  input  logic                         end_sel_i,
  input  ietf_pkg::ietf_cell_wr_t      wr_i,
  output logic                         bit_o,
  output logic                         hit_o,
  output logic [ietf_pkg::PIECE_W-1:0] end_idx_o
);
  import ietf_pkg::*;

  logic               start_q;
  logic               cont_q;
  logic               end_q;
  logic [PIECE_W-1:0] end_idx_q;
  logic               bit_q;
  logic               bit_d;

  // a needle starts here, or continues from a match that ended one cell back
  assign bit_d = (start_q || (cont_q && prev_i)) && (upcase(filt_byte_i) == char_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b0;
      cont_q  <= 1'b0;
      end_q   <= 1'b0;
      bit_q   <= 1'b0;
    end else begin
      if (sweep_sel_i) begin
        start_q <= wr_i.start;
        cont_q  <= wr_i.cont;
        end_q   <= 1'b0;
      end else if (end_sel_i) begin
        end_q <= 1'b1;
      end
      if (step_i) begin
        bit_q <= bit_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (end_sel_i && !sweep_sel_i) begin
      end_idx_q <= wr_i.end_idx;
    end
  end

  assign bit_o     = bit_q;
  assign hit_o     = bit_q && end_q;
  assign end_idx_o = end_idx_q;

endmodule

`default_nettype wire

// ===== design/ietf_parser.sv =====
`default_nettype none

module ietf_parser #(
  parameter int FILTER_BYTES = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  logic [FILTER_BYTES*8-1:0]       str_i,
  output logic                            busy_o,
  output logic [FILTER_BYTES-1:0]         sweep_sel_o,
  output logic [FILTER_BYTES-1:0]         end_sel_o,
  output ietf_pkg::ietf_cell_wr_t         wr_o,
  output logic [ietf_pkg::MAX_PIECES-1:0] exists_o,
  output logic [ietf_pkg::MAX_PIECES-1:0] excl_o,
  output logic                            incl_any_o
);
  import ietf_pkg::*;

  localparam int PW = $clog2(FILTER_BYTES);
  localparam logic [PW-1:0] LAST_POS = PW'(FILTER_BYTES - 1);

  ietf_pstate_e state_q, state_d;

  logic [FILTER_BYTES*8-1:0] sh_q;
  logic [PW-1:0]             pos_q;
  logic [PW-1:0]             lastnb_q;
  logic [PIDX_W-1:0]         idx_q;
  logic                      done_q;
  logic                      seen_q;
  logic                      excl_q;
  logic                      started_q;
  logic                      nb_q;
  logic [MAX_PIECES-1:0]     exists_q;
  logic [MAX_PIECES-1:0]     exclb_q;
  logic                      incl_q;

  logic [7:0] cur;
  logic       in_sweep;
  logic       is_term;
  logic       is_comma;
  logic       is_text;
  logic       cur_blank;
  logic       close;
  logic       piece_ok;

  assign cur       = sh_q[7:0];
  assign cur_blank = is_blank(cur);
  assign in_sweep  = (state_q == PS_SWEEP);
  // string ends at the first zero byte, the top byte always counts as zero
  assign is_term   = done_q || (cur == CHAR_NUL) || (pos_q == LAST_POS);
  assign is_comma  = !is_term && (cur == CHAR_COMMA);
  assign is_text   = !is_term && !is_comma;
  assign close     = in_sweep && !done_q && (is_term || is_comma);
  assign piece_ok  = !idx_q[PIDX_W-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    busy_o      = 1'b0;
    wr_o        = '0;
    wr_o.end_idx = idx_q[PIECE_W-1:0];
    case (state_q)
      PS_IDLE: begin
        if (load_i) begin
          state_d = PS_SWEEP;
        end
      end
      PS_SWEEP: begin
        busy_o = 1'b1;
        if (is_text) begin
          if (!seen_q) begin
            wr_o.start = !cur_blank && (cur != CHAR_DASH);
          end else if (!started_q) begin
            // first byte after a leading dash, blank or not
            wr_o.start = 1'b1;
          end else begin
            wr_o.cont = 1'b1;
          end
        end
        if (load_i) begin
          state_d = PS_SWEEP;
        end else if (pos_q == LAST_POS) begin
          state_d = PS_IDLE;
        end
      end
      default: begin
        state_d = PS_IDLE;
      end
    endcase
  end

  for (genvar q = 0; q < FILTER_BYTES; q++) begin : g_sel
    assign sweep_sel_o[q] = in_sweep && (pos_q == PW'(q));
    assign end_sel_o[q]   = close && piece_ok && nb_q && (lastnb_q == PW'(q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      idx_q     <= '0;
      done_q    <= 1'b0;
      seen_q    <= 1'b0;
      excl_q    <= 1'b0;
      started_q <= 1'b0;
      nb_q      <= 1'b0;
      exists_q  <= '0;
      exclb_q   <= '0;
      incl_q    <= 1'b0;
    end else if (load_i) begin
      pos_q     <= '0;
      idx_q     <= '0;
      done_q    <= 1'b0;
      seen_q    <= 1'b0;
      excl_q    <= 1'b0;
      started_q <= 1'b0;
      nb_q      <= 1'b0;
      exists_q  <= '0;
      exclb_q   <= '0;
      incl_q    <= 1'b0;
    end else if (in_sweep) begin
      pos_q <= pos_q + 1'b1;
      if (close) begin
        done_q    <= is_term;
        seen_q    <= 1'b0;
        excl_q    <= 1'b0;
        started_q <= 1'b0;
        nb_q      <= 1'b0;
        if (piece_ok) begin
          idx_q <= idx_q + 1'b1;
        end
        if (piece_ok && seen_q) begin
          exists_q[idx_q[PIECE_W-1:0]] <= 1'b1;
          exclb_q[idx_q[PIECE_W-1:0]]  <= excl_q;
          if (!excl_q) begin
            incl_q <= 1'b1;
          end
        end
      end else if (is_text) begin
        if (!seen_q) begin
          if (!cur_blank) begin
            seen_q <= 1'b1;
            if (cur == CHAR_DASH) begin
              excl_q <= 1'b1;
            end else begin
              started_q <= 1'b1;
              nb_q      <= 1'b1;
            end
          end
        end else begin
          started_q <= 1'b1;
          if (!cur_blank) begin
            nb_q <= 1'b1;
          end
        end
      end
    end
  end

  // filter byte shifter, and the last non-blank needle byte, where the piece's end mark goes
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sh_q <= str_i;
    end else if (in_sweep) begin
      sh_q <= sh_q >> 8;
    end
    if (in_sweep && is_text && !cur_blank && (seen_q || (cur != CHAR_DASH))) begin
      lastnb_q <= pos_q;
    end
  end

  assign exists_o   = exists_q;
  assign excl_o     = exclb_q;
  assign incl_any_o = incl_q;

endmodule

`default_nettype wire

// ===== design/include_exclude_text_filter_unit.sv =====
`default_nettype none

// channel    dir  handshake      word
// text_i     in   valid/ready    text_byte, byte_present, last_byte
// verdict_o  out  valid/ready    passes, verdict_kind, deciding_piece
// apb        in   psel/penable   filter words, 8 bytes each at paddr 8*i
//
// one text byte per cycle when not stalled; a verdict passes the registered input
// stage, then turns valid in a one-deep output stage that holds it while later bytes flow.
// every filter word write starts a parse sweep over all FILTER_BYTES filter bytes, one
// filter byte per cycle, and text_i is not ready until it ends.
// reset leaves an empty filter, nothing to parse.
// a pending verdict stalls text_i only when the next last word reaches it.

module include_exclude_text_filter_unit #(
  parameter int  FILTER_BYTES = 64,
  localparam int NWORDS = (FILTER_BYTES + 7) / 8,
  localparam int IW = (NWORDS > 1) ? $clog2(NWORDS) : 1,
  localparam int AW = IW + 3
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  ietf_stream_if.sink                text_i,
  ietf_stream_if.source              verdict_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [AW-1:0]              paddr,
  input  logic [ietf_pkg::CFG_W-1:0] pwdata,
  output logic [ietf_pkg::CFG_W-1:0] prdata,
  output logic                       pready
);
  import ietf_pkg::*;

  // configuration words
  logic [NWORDS*CFG_W-1:0] cfg_q;
  logic [NWORDS*CFG_W-1:0] cfg_d;
  logic [IW-1:0]           aidx;
  logic                    aidx_ok;
  logic                    cfg_wr;

  assign pready  = 1'b1;
  assign aidx    = paddr[AW-1:3];
  assign aidx_ok = (int'(aidx) < NWORDS);
  assign cfg_wr  = psel && penable && pwrite && aidx_ok;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      cfg_d[{aidx, 6'd0} +: CFG_W] = pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign prdata = aidx_ok ? cfg_q[{aidx, 6'd0} +: CFG_W] : '0;

  // parser
  logic                  parse_busy;
  logic [FILTER_BYTES-1:0] sweep_sel;
  logic [FILTER_BYTES-1:0] end_sel;
  ietf_cell_wr_t         cell_wr;
  logic [MAX_PIECES-1:0] piece_exists;
  logic [MAX_PIECES-1:0] piece_excl;
  logic                  incl_any;

  ietf_parser #(
    .FILTER_BYTES(FILTER_BYTES)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (cfg_wr),
    .str_i      (cfg_d[FILTER_BYTES*8-1:0]),
    .busy_o     (parse_busy),
    .sweep_sel_o(sweep_sel),
    .end_sel_o  (end_sel),
    .wr_o       (cell_wr),
    .exists_o   (piece_exists),
    .excl_o     (piece_excl),
    .incl_any_o (incl_any)
  );

  // input side
  logic       adv;
  logic       accept;
  logic       step;
  logic [7:0] char_up;
  logic       clr_q;
  logic       a_valid_q;
  logic       a_present_q;
  logic       a_last_q;
  logic       final_valid_q;

  // only a last word meeting a still-pending verdict holds the row
  assign adv          = !(a_valid_q && a_last_q && final_valid_q && !verdict_o.ready);
  assign text_i.ready = adv && !parse_busy;
  assign accept       = text_i.valid && text_i.ready;
  assign step         = accept && text_i.payload.byte_present;
  assign char_up      = upcase(text_i.payload.text_byte);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= 1'b1;
      a_valid_q   <= 1'b0;
      a_present_q <= 1'b0;
      a_last_q    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        clr_q <= 1'b1;
      end else if (accept) begin
        // partial matches restart after a text ends, until a real byte comes
        clr_q <= text_i.payload.last_byte || (clr_q && !text_i.payload.byte_present);
      end
      if (adv) begin
        a_valid_q   <= accept;
        a_present_q <= text_i.payload.byte_present;
        a_last_q    <= text_i.payload.last_byte;
      end
    end
  end

  // cell row
  logic [FILTER_BYTES-1:0] cell_bit;
  logic [FILTER_BYTES-1:0] cell_hit;
  logic [PIECE_W-1:0]      cell_end_idx [FILTER_BYTES];

  for (genvar p = 0; p < FILTER_BYTES; p++) begin : g_cell
    logic prev;
    if (p == 0) begin : g_head
      assign prev = 1'b0;
    end else begin : g_link
      assign prev = cell_bit[p-1] && !clr_q;
    end
    ietf_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .filt_byte_i(cfg_q[8*p +: 8]),
      .char_i     (char_up),
      .step_i     (step),
      .prev_i     (prev),
      .sweep_sel_i(sweep_sel[p]),
      .end_sel_i  (end_sel[p]),
      .wr_i       (cell_wr),
      .bit_o      (cell_bit[p]),
      .hit_o      (cell_hit[p]),
      .end_idx_o  (cell_end_idx[p])
    );
  end

  // found flags
  logic [MAX_PIECES-1:0] hit_flags;
  logic [MAX_PIECES-1:0] acc;
  logic [MAX_PIECES-1:0] found_q;
  logic [MAX_PIECES-1:0] final_q;

  always_comb begin
    hit_flags = '0;
    for (int p = 0; p < FILTER_BYTES; p++) begin
      if (cell_hit[p]) begin
        hit_flags[cell_end_idx[p]] = 1'b1;
      end
    end
  end

  assign acc = found_q | (a_present_q ? hit_flags : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q       <= '0;
      final_valid_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        found_q <= '0;
      end else if (adv && a_valid_q) begin
        found_q <= a_last_q ? '0 : acc;
      end
      if (adv && a_valid_q && a_last_q) begin
        final_valid_q <= 1'b1;
      end else if (verdict_o.ready) begin
        final_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && a_valid_q && a_last_q) begin
      final_q <= acc;
    end
  end

  // verdict: first matched piece in list order
  logic               any_found;
  logic [PIECE_W-1:0] first;
  ietf_verdict_e      kind;

  always_comb begin
    any_found = |final_q;
    first     = '0;
    for (int i = MAX_PIECES - 1; i >= 0; i--) begin
      if (final_q[i]) begin
        first = PIECE_W'(i);
      end
    end
    if (any_found) begin
      kind = piece_excl[first] ? VK_EXCLUDE : VK_INCLUDE;
    end else begin
      kind = incl_any ? VK_NO_MATCH : VK_NO_INCLUDES;
    end
  end

  assign verdict_o.valid                  = final_valid_q;
  assign verdict_o.payload.passes         = (kind == VK_INCLUDE) || (kind == VK_NO_INCLUDES);
  assign verdict_o.payload.verdict_kind   = kind;
  assign verdict_o.payload.deciding_piece = any_found ? first : '0;

  a_found_exists: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (found_q & ~piece_exists) == '0)
    else $error("found flag set for a piece that does not exist");

  a_excl_exists: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (piece_excl & ~piece_exists) == '0)
    else $error("exclude flag set for a piece that does not exist");

  a_verdict_piece: assert property (@(posedge clk_i) disable iff (!rst_ni)
    verdict_o.valid && ((verdict_o.payload.verdict_kind == VK_INCLUDE) ||
                        (verdict_o.payload.verdict_kind == VK_EXCLUDE))
    |-> piece_exists[verdict_o.payload.deciding_piece])
    else $error("deciding piece does not exist");

  a_write_parses: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> parse_busy && !text_i.ready)
    else $error("filter write did not start a parse sweep");

endmodule

`default_nettype wire

// ===== verif/tb_include_exclude_text_filter_unit.sv =====
module tb_include_exclude_text_filter_unit;
  import ietf_pkg::*;

  localparam int FILTER_BYTES = 64;
  localparam int NUM_WORDS    = FILTER_BYTES / 8;
  localparam int ADDR_W       = $clog2(NUM_WORDS) + 3;
  localparam int ITEM_GOAL    = 2000;
  localparam int QUIET_LIMIT  = 3000;
  localparam int LONG_HOLD    = 300;
  localparam int IDLE_PCT     = 38;
  localparam int SETTLE       = 8;
  localparam logic [7:0] CHAR_UPPER_A = "A";
  localparam logic [7:0] CHAR_UPPER_Z = "Z";

  // predicts verdicts from the filter words and the accepted text words
  class filter_scoreboard;
    logic [7:0]    filter_chr[FILTER_BYTES];
    bit            starts_needle[FILTER_BYTES];
    bit            continues_needle[FILTER_BYTES];
    int            ends_piece[FILTER_BYTES];
    bit [31:0]     piece_used;
    bit [31:0]     piece_is_excl;
    int            n_includes;
    bit [FILTER_BYTES-1:0] partial;
    bit [31:0]     found;
    ietf_verdict_t verdicts_due[$];
    int            errors;
    int            verdicts_checked;

    function new();
      foreach (filter_chr[i]) filter_chr[i] = CHAR_NUL;
      errors = 0;
      verdicts_checked = 0;
      reparse();
      partial = '0;
      found = '0;
    endfunction

    function logic [7:0] to_upper(logic [7:0] c);
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) return c - CASE_OFFSET;
      return c;
    endfunction

    function bit blank(logic [7:0] c);
      return c == CHAR_SPACE || c == CHAR_TAB;
    endfunction

    function void add_piece(int idx, int b, int e);
      while (b < e && blank(filter_chr[b])) b++;
      while (e > b && blank(filter_chr[e-1])) e--;
      if (idx >= MAX_PIECES || b == e) return;
      piece_used[idx] = 1'b1;
      if (filter_chr[b] == CHAR_DASH) begin
        piece_is_excl[idx] = 1'b1;
        b++;
      end else begin
        n_includes++;
      end
      // a lone dash leaves nothing to search for
      if (b == e) return;
      starts_needle[b] = 1'b1;
      for (int p = b + 1; p < e; p++) continues_needle[p] = 1'b1;
      ends_piece[e-1] = idx + 1;
    endfunction

    function void reparse();
      int len;
      int wb;
      int idx;
      foreach (starts_needle[i]) begin
        starts_needle[i] = 1'b0;
        continues_needle[i] = 1'b0;
        ends_piece[i] = 0;
      end
      piece_used = '0;
      piece_is_excl = '0;
      n_includes = 0;
      len = 0;
      while (len < FILTER_BYTES - 1 && filter_chr[len] != CHAR_NUL) len++;
      wb = 0;
      idx = 0;
      for (int p = 0; p < len; p++) begin
        if (filter_chr[p] == CHAR_COMMA) begin
          add_piece(idx, wb, p);
          idx++;
          wb = p + 1;
        end
      end
      if (wb != len) add_piece(idx, wb, len);
    endfunction

    function void load_word(int idx, logic [63:0] value);
      // the top filter byte always reads as zero
      for (int k = 0; k < 8; k++) begin
        if (8 * idx + k < FILTER_BYTES - 1) filter_chr[8*idx+k] = value[8*k +: 8];
      end
      reparse();
      partial = '0;
      found = '0;
    endfunction

    function void note_text(ietf_text_t w);
      logic [7:0]    c;
      bit            hit;
      ietf_verdict_t exp;
      c = to_upper(w.text_byte);
      if (w.byte_present) begin
        // walk downward so the lower neighbor still holds its old bit
        for (int p = FILTER_BYTES - 1; p >= 0; p--) begin
          hit = (starts_needle[p] || (continues_needle[p] && p > 0 && partial[p-1]))
                && to_upper(filter_chr[p]) == c;
          partial[p] = hit;
          if (hit && ends_piece[p] != 0) found[ends_piece[p]-1] = 1'b1;
        end
      end
      if (!w.last_byte) return;
      exp.passes = (n_includes == 0);
      exp.verdict_kind = (n_includes == 0) ? VK_NO_INCLUDES : VK_NO_MATCH;
      exp.deciding_piece = '0;
      for (int i = 0; i < MAX_PIECES; i++) begin
        if (piece_used[i] && found[i]) begin
          exp.passes = !piece_is_excl[i];
          exp.verdict_kind = piece_is_excl[i] ? VK_EXCLUDE : VK_INCLUDE;
          exp.deciding_piece = PIECE_W'(i);
          break;
        end
      end
      verdicts_due.insert(verdicts_due.size(), exp);
      partial = '0;
      found = '0;
    endfunction

    function void check_verdict(ietf_verdict_t got);
      ietf_verdict_t exp;
      if (verdicts_due.size() == 0) begin
        $error("verdict with none pending: passes %0b kind %0d piece %0d",
               got.passes, got.verdict_kind, got.deciding_piece);
        errors++;
        return;
      end
      exp = verdicts_due.pop_front();
      verdicts_checked++;
      if (got.passes !== exp.passes) begin
        $error("passes: expected %0b, got %0b", exp.passes, got.passes);
        errors++;
      end
      if (got.verdict_kind !== exp.verdict_kind) begin
        $error("verdict_kind: expected %0d, got %0d", exp.verdict_kind, got.verdict_kind);
        errors++;
      end
      if (got.deciding_piece !== exp.deciding_piece) begin
        $error("deciding_piece: expected %0d, got %0d", exp.deciding_piece,
               got.deciding_piece);
        errors++;
      end
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [CFG_W-1:0]    pwdata;
  logic [CFG_W-1:0]    prdata;
  logic                pready;

  ietf_stream_if #(.payload_t(ietf_text_t))    text_if ();
  ietf_stream_if #(.payload_t(ietf_verdict_t)) verdict_if ();

  include_exclude_text_filter_unit dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .text_i   (text_if),
    .verdict_o(verdict_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  filter_scoreboard sb = new();

  int         words_sent;
  int         filters_loaded;
  int         hold_requests;
  bit         no_idle;
  int         quiet_cycles;
  logic [7:0] fq[$];
  logic [7:0] tq[$];
  int         nb_q[$];
  int         ne_q[$];
  string      filler_chars = "abcdeABCDExyz -";

  always #5 clk_i = ~clk_i;

  // scoreboard feed and watchdog
  always @(posedge clk_i) begin : monitor
    logic moved;
    if (rst_ni) begin
      moved = psel && penable;
      if (text_if.valid && text_if.ready) begin
        sb.note_text(text_if.payload);
        moved = 1'b1;
      end
      if (verdict_if.valid && verdict_if.ready) begin
        sb.check_verdict(verdict_if.payload);
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // verdict receiver, with a long hold-off on request
  initial begin : verdict_sink
    int hold_left;
    int holds_served;
    hold_left = 0;
    holds_served = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && holds_served < hold_requests) begin
        hold_left = LONG_HOLD;
        holds_served++;
      end
      if (hold_left != 0) begin
        verdict_if.ready <= 1'b0;
        hold_left--;
      end else begin
        verdict_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic write_filter_word(int idx, logic [63:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(8 * idx);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.load_word(idx, value);
  endtask

  task automatic program_filter();
    logic [63:0] w;
    for (int i = 0; i < NUM_WORDS; i++) begin
      w = '0;
      for (int k = 0; k < 8; k++) begin
        if (8 * i + k < fq.size()) w[8*k +: 8] = fq[8*i+k];
      end
      write_filter_word(i, w);
    end
    filters_loaded++;
  endtask

  task automatic program_filter_str(string s);
    fq.delete();
    nb_q.delete();
    ne_q.delete();
    for (int i = 0; i < s.len(); i++) fq.insert(fq.size(), s[i]);
    program_filter();
  endtask

  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic push_word(logic [7:0] b, logic present, logic last);
    ietf_text_t w;
    w.text_byte = b;
    w.byte_present = present;
    w.last_byte = last;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      text_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    text_if.valid   <= 1'b1;
    text_if.payload <= w;
    do @(posedge clk_i); while (!text_if.ready);
    if (present || last) words_sent++;
  endtask

  // sends tq as one text; an empty tq becomes a lone absent last word
  task automatic send_text();
    if (tq.size() == 0) begin
      push_word(8'($urandom_range(255)), 1'b0, 1'b1);
      return;
    end
    for (int i = 0; i < tq.size(); i++) begin
      if ($urandom_range(99) < 5) push_word(8'($urandom_range(255)), 1'b0, 1'b0);
      push_word(tq[i], 1'b1, i == tq.size() - 1);
    end
  endtask

  task automatic send_str(string s);
    tq.delete();
    for (int i = 0; i < s.len(); i++) tq.insert(tq.size(), s[i]);
    send_text();
  endtask

  function automatic logic [7:0] flip_case(logic [7:0] c);
    bit letter;
    letter = (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ||
             (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z);
    if (letter && $urandom_range(1) == 1) return c ^ CASE_OFFSET;
    return c;
  endfunction

  function automatic logic [7:0] needle_char();
    if ($urandom_range(99) < 90) return filler_chars[$urandom_range(9)];
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic build_filter();
    int n;
    int kind;
    int start;
    fq.delete();
    nb_q.delete();
    ne_q.delete();
    n = ($urandom_range(9) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 6);
    for (int k = 0; k < n; k++) begin
      if (k > 0) fq.insert(fq.size(), CHAR_COMMA);
      repeat ($urandom_range(0, 2)) begin
        fq.insert(fq.size(), $urandom_range(1) ? CHAR_SPACE : CHAR_TAB);
      end
      kind = $urandom_range(99);
      if (kind < 8) begin
        // empty piece keeps its index
      end else if (kind < 14) begin
        fq.insert(fq.size(), CHAR_DASH);
      end else begin
        if (kind < 45) fq.insert(fq.size(), CHAR_DASH);
        start = fq.size();
        repeat ($urandom_range(1, 5)) fq.insert(fq.size(), needle_char());
        nb_q.insert(nb_q.size(), start);
        ne_q.insert(ne_q.size(), fq.size());
      end
      repeat ($urandom_range(0, 2)) begin
        fq.insert(fq.size(), $urandom_range(1) ? CHAR_SPACE : CHAR_TAB);
      end
    end
    if ($urandom_range(9) == 0) fq.insert(fq.size(), CHAR_COMMA);
  endtask

  task automatic build_text();
    int mode;
    int r;
    int s;
    int n;
    tq.delete();
    mode = $urandom_range(99);
    if (mode < 6) return;
    if (mode < 25) begin
      repeat ($urandom_range(1, 10)) tq.insert(tq.size(), 8'($urandom_range(255)));
      return;
    end
    repeat ($urandom_range(1, 4)) begin
      r = $urandom_range(99);
      if (r < 55 && nb_q.size() > 0) begin
        s = $urandom_range(nb_q.size() - 1);
        for (int p = nb_q[s]; p < ne_q[s]; p++) begin
          tq.insert(tq.size(), flip_case(fq[p]));
        end
      end else if (r < 75 && fq.size() > 0) begin
        s = $urandom_range(fq.size() - 1);
        n = $urandom_range(1, 6);
        for (int p = s; p < s + n && p < fq.size(); p++) begin
          tq.insert(tq.size(), flip_case(fq[p]));
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          tq.insert(tq.size(), filler_chars[$urandom_range(14)]);
        end
      end
    end
  endtask

  initial begin : stimulus
    int phase;
    int target;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    text_if.valid = 1'b0;
    text_if.payload = '0;
    verdict_if.ready = 1'b0;
    words_sent = 0;
    filters_loaded = 0;
    hold_requests = 0;
    no_idle = 1'b0;
    quiet_cycles = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty filter after reset: everything passes
    send_str("a");
    send_str("");
    tq = '{8'h00};
    send_text();
    tq = '{8'hff};
    send_text();
    push_word(8'($urandom_range(255)), 1'b0, 1'b0);
    send_str("b");
    text_if.valid <= 1'b0;

    // blanks trimmed, empty piece, lone dash, trailing comma, mixed case
    wait_idle();
    program_filter_str("  Foo\t, -bar ,,-, baz,");
    send_str("xFOOy");
    send_str("BAR");
    send_str("-");
    send_str("bAz");
    send_str("FOO-BAR");
    text_if.valid <= 1'b0;

    // pieces past the 32nd are dropped, so no include counts
    wait_idle();
    fq.delete();
    repeat (40) fq.insert(fq.size(), CHAR_COMMA);
    fq.insert(fq.size(), "z");
    fq.insert(fq.size(), "z");
    fq.insert(fq.size(), CHAR_COMMA);
    fq.insert(fq.size(), CHAR_DASH);
    fq.insert(fq.size(), "q");
    program_filter();
    send_str("zz");
    text_if.valid <= 1'b0;

    // a piece in the top byte is cut off by the forced terminator
    wait_idle();
    fq.delete();
    repeat (FILTER_BYTES - 2) fq.insert(fq.size(), "a");
    fq.insert(fq.size(), CHAR_COMMA);
    fq.insert(fq.size(), "q");
    program_filter();
    send_str("q");
    text_if.valid <= 1'b0;

    // all filter bits set
    wait_idle();
    fq.delete();
    repeat (FILTER_BYTES) fq.insert(fq.size(), 8'hff);
    program_filter();
    tq = '{8'hff};
    send_text();
    text_if.valid <= 1'b0;

    nb_q.delete();
    ne_q.delete();
    phase = 0;
    while (words_sent < ITEM_GOAL) begin
      wait_idle();
      if (phase % 5 == 4) begin
        fq.delete();
        nb_q.delete();
        ne_q.delete();
        repeat (FILTER_BYTES) fq.insert(fq.size(), 8'($urandom_range(255)));
      end else begin
        build_filter();
      end
      program_filter();
      no_idle = (phase == 2);
      if (phase == 4) hold_requests++;
      target = words_sent + $urandom_range(60, 140);
      while (words_sent < target) begin
        build_text();
        send_text();
      end
      text_if.valid <= 1'b0;
      phase++;
    end
    no_idle = 1'b0;

    wait_idle();
    if (sb.pending() != 0) $error("%0d verdicts never arrived", sb.pending());
    $display("run covered %0d text words, %0d verdicts checked, %0d filter settings",
             words_sent, sb.verdicts_checked, filters_loaded);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/ietf_pkg.sv
design/ietf_stream_if.sv
design/ietf_cell.sv
design/ietf_parser.sv
design/include_exclude_text_filter_unit.sv
verif/tb_include_exclude_text_filter_unit.sv
